[src/prx_pkg.sv]
// Shared types and constants of the printable run extractor.
package prx_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned StoreDepth  = BufferDepth - 1;
  localparam int unsigned CntW        = $clog2(BufferDepth);
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned MinLenW     = 7;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;

  localparam logic [CntW-1:0]    STORE_FULL   = CntW'(StoreDepth);
  localparam logic [MinLenW-1:0] MIN_LEN_RST  = 7'd4;
  localparam logic [7:0]         PRINT_LO     = 8'h20;
  localparam logic [7:0]         PRINT_HI     = 8'h7E;
  localparam logic [7:0]         NEWLINE_CODE = 8'd10;
  localparam logic               REG_MIN_LEN  = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
  } out_beat_t;

  typedef struct packed {
    logic take;
    logic stream;
    logic send_nl;
    logic end_ovf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_flush;
    logic drained;
    logic with_nl;
    logic slot_free;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_NL    = 3'b100
  } ctrl_state_e;

endpackage

[src/prx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/prx_datapath.sv]
// Datapath: run store, counters, config register and output register.
module prx_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prx_pkg::in_beat_t             in_beat_i,
  output prx_pkg::out_beat_t            out_beat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  prx_pkg::ctrl_cmd_t            cmd_i,
  output prx_pkg::dp_stat_t             stat_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prx_pkg::PaddrW-1:0]    paddr,
  input  logic [prx_pkg::PdataW-1:0]    pwdata,
  output logic [prx_pkg::PdataW-1:0]    prdata
);

  logic [prx_pkg::CntW-1:0]    count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic [prx_pkg::MinLenW-1:0] min_len_q, min_len_d;
  logic [prx_pkg::CntW-1:0]    rd_idx_q, rd_idx_d;
  logic [prx_pkg::CntW-1:0]    emit_len_q, emit_len_d;
  logic                        rv_q, rv_d;
  logic                        ov_q, ov_d;
  logic                        nl_q, nl_d;
  logic                        eof_q, eof_d;
  logic [7:0]                  pend_q, pend_d;
  prx_pkg::out_beat_t          out_q, out_d;

  logic                        printable, full, go_flush;
  logic                        slot_free, load, issue, nl_load;
  logic                        we;
  logic [prx_pkg::AddrW-1:0]   waddr;
  logic [7:0]                  wdata, rdata;
  logic                        reg_sel;

  assign printable = (in_beat_i.data_byte >= prx_pkg::PRINT_LO) &&
                     (in_beat_i.data_byte <= prx_pkg::PRINT_HI);
  assign full      = (count_q == prx_pkg::STORE_FULL);
  assign go_flush  = printable ? full : (ovf_q || ({1'b0, count_q} >= min_len_q));

  assign slot_free = !ov_q || !out_stall_i;
  assign load      = cmd_i.stream && rv_q && slot_free;
  assign issue     = cmd_i.stream && (rd_idx_q != emit_len_q) && (!rv_q || load);
  assign nl_load   = cmd_i.send_nl && slot_free;

  assign stat_o.go_flush  = go_flush;
  assign stat_o.drained   = (rd_idx_q == emit_len_q) && !rv_q;
  assign stat_o.with_nl   = nl_q;
  assign stat_o.slot_free = slot_free;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[prx_pkg::AddrW-1:0];
    wdata = in_beat_i.data_byte;
    if (cmd_i.take && printable && !full) begin
      we = 1'b1;
    end else if (cmd_i.end_ovf) begin
      we    = 1'b1;
      waddr = '0;
      wdata = pend_q;
    end
  end

  prx_ram #(
    .Width (8),
    .Depth (prx_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rd_idx_q[prx_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign reg_sel = (paddr[2] == prx_pkg::REG_MIN_LEN);

  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    min_len_d  = min_len_q;
    rd_idx_d   = rd_idx_q;
    emit_len_d = emit_len_q;
    rv_d       = rv_q;
    ov_d       = ov_q;
    nl_d       = nl_q;
    eof_d      = eof_q;
    pend_d     = pend_q;
    out_d      = out_q;

    if (psel && penable && pwrite && reg_sel) begin
      min_len_d = pwdata[prx_pkg::MinLenW-1:0];
    end

    if (cmd_i.take) begin
      if (printable && !full) begin
        count_d = count_q + 1'b1;
        if (in_beat_i.file_end) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end else if (go_flush) begin
        emit_len_d = printable ? prx_pkg::STORE_FULL : count_q;
        nl_d       = !printable;
        pend_d     = in_beat_i.data_byte;
        eof_d      = in_beat_i.file_end;
        rd_idx_d   = '0;
        rv_d       = 1'b0;
      end else begin
        count_d = '0;
      end
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
    if (issue) begin
      rv_d = 1'b1;
    end else if (load) begin
      rv_d = 1'b0;
    end

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d                = 1'b1;
      out_d.out_byte      = rdata;
      out_d.last_of_burst = !nl_q && (rd_idx_q == emit_len_q);
    end else if (nl_load) begin
      ov_d                = 1'b1;
      out_d.out_byte      = prx_pkg::NEWLINE_CODE;
      out_d.last_of_burst = 1'b1;
      count_d             = '0;
      ovf_d               = 1'b0;
    end

    if (cmd_i.end_ovf) begin
      count_d = eof_q ? '0 : prx_pkg::CntW'(1);
      ovf_d   = !eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      min_len_q <= prx_pkg::MIN_LEN_RST;
      rd_idx_q  <= '0;
      rv_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      min_len_q <= min_len_d;
      rd_idx_q  <= rd_idx_d;
      rv_q      <= rv_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_len_q <= emit_len_d;
    nl_q       <= nl_d;
    eof_q      <= eof_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign out_beat_o  = out_q;
  assign out_valid_o = ov_q;
  assign prdata      = reg_sel ? prx_pkg::PdataW'(min_len_q) : '0;

endmodule

[src/prx_ctrl.sv]
// Controller: accepts input beats and sequences run flushes.
module prx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  prx_pkg::dp_stat_t  stat_i,
  output prx_pkg::ctrl_cmd_t cmd_o
);

  prx_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      prx_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.go_flush) begin
            state_d = prx_pkg::ST_FLUSH;
          end
        end
      end
      prx_pkg::ST_FLUSH: begin
        cmd_o.stream = 1'b1;
        if (stat_i.drained) begin
          if (stat_i.with_nl) begin
            state_d = prx_pkg::ST_NL;
          end else begin
            cmd_o.end_ovf = 1'b1;
            state_d       = prx_pkg::ST_IDLE;
          end
        end
      end
      prx_pkg::ST_NL: begin
        cmd_o.send_nl = 1'b1;
        if (stat_i.slot_free) begin
          state_d = prx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/printable_run_extractor.sv]
// Top level of the printable run extractor.
// Input channel: one file byte per beat (in_valid_i / in_stall_o), with a
// file_end flag on the last byte of a file. Output channel: one emitted
// byte per beat (out_valid_o / out_stall_i); last_of_burst marks the final
// beat caused by one input byte. min_length sits at APB byte address 0.
// A printable byte that fits in the run store is taken and produces
// nothing. A byte that ends a reported run, or overflows the store,
// starts a flush: the held bytes stream out of the single read port of
// the run store at one beat per cycle while the receiver does not stall,
// behind the registered read; then the store is seen drained and, after
// a reported run, the newline is sent. Input is stalled during a flush.
// The output register lets the next input beat be taken while the last
// result still waits.
// When the receiver stalls, the output beat holds and the flush pauses.
// Reset empties the run, clears the overflow mark and sets min_length to 4;
// the run store itself needs no clearing.
module printable_run_extractor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  prx_pkg::in_beat_t          in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output prx_pkg::out_beat_t         out_beat_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [prx_pkg::PaddrW-1:0] paddr,
  input  logic [prx_pkg::PdataW-1:0] pwdata,
  output logic [prx_pkg::PdataW-1:0] prdata,
  output logic                       pready
);

  prx_pkg::ctrl_cmd_t cmd;
  prx_pkg::dp_stat_t  stat;

  assign pready = 1'b1;

  prx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prx_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .out_beat_o  (out_beat_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule

[tb/printable_run_extractor_tb.sv]
// Self-checking testbench of the printable run extractor: random byte streams against a predictor.
module printable_run_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  prx_pkg::in_beat_t          in_beat  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  prx_pkg::out_beat_t         out_beat;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [prx_pkg::PaddrW-1:0] paddr   = '0;
  logic [prx_pkg::PdataW-1:0] pwdata  = '0;
  logic [prx_pkg::PdataW-1:0] prdata;
  logic                       pready;

  prx_pkg::in_beat_t  bytes_to_send[$];
  prx_pkg::out_beat_t pending_emits[$];
  logic [7:0]         held_run[prx_pkg::StoreDepth];
  int unsigned        held_len       = 0;
  bit                 run_overflowed = 1'b0;
  int unsigned        min_len        = int'(prx_pkg::MIN_LEN_RST);

  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  bit          idle_on    = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  logic        in_fire;

  printable_run_extractor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  function automatic void flag_error(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", what);
    end
  endfunction

  function automatic void push_emit(logic [7:0] b);
    prx_pkg::out_beat_t e;
    e.out_byte      = b;
    e.last_of_burst = 1'b0;
    pending_emits.push_back(e);
  endfunction

  function automatic void predict_emission(prx_pkg::in_beat_t b);
    int unsigned        before_cnt;
    prx_pkg::out_beat_t tail;
    before_cnt = pending_emits.size();
    if (b.data_byte >= prx_pkg::PRINT_LO && b.data_byte <= prx_pkg::PRINT_HI) begin
      if (held_len >= prx_pkg::StoreDepth) begin
        for (int i = 0; i < held_len; i++) begin
          push_emit(held_run[i]);
        end
        run_overflowed = 1'b1;
        held_len       = 0;
      end
      held_run[held_len] = b.data_byte;
      held_len++;
    end else if (run_overflowed || held_len >= min_len) begin
      for (int i = 0; i < held_len; i++) begin
        push_emit(held_run[i]);
      end
      push_emit(prx_pkg::NEWLINE_CODE);
      run_overflowed = 1'b0;
      held_len       = 0;
    end else begin
      held_len = 0;
    end
    if (pending_emits.size() > before_cnt) begin
      tail = pending_emits[pending_emits.size() - 1];
      tail.last_of_burst = 1'b1;
      pending_emits[pending_emits.size() - 1] = tail;
    end
    if (b.file_end) begin
      held_len       = 0;
      run_overflowed = 1'b0;
    end
  endfunction

  function automatic void check_beat(prx_pkg::out_beat_t got);
    prx_pkg::out_beat_t want;
    if (pending_emits.size() == 0) begin
      flag_error($sformatf("unexpected beat byte %02h last %0b", got.out_byte,
                           got.last_of_burst));
      return;
    end
    want = pending_emits.pop_front();
    if (got.out_byte !== want.out_byte) begin
      flag_error($sformatf("out_byte expected %02h got %02h", want.out_byte, got.out_byte));
    end
    if (got.last_of_burst !== want.last_of_burst) begin
      flag_error($sformatf("last_of_burst expected %0b got %0b (byte %02h)",
                           want.last_of_burst, got.last_of_burst, want.out_byte));
    end
  endfunction

  function automatic void queue_byte(logic [7:0] d, logic eof);
    prx_pkg::in_beat_t b;
    b.data_byte = d;
    b.file_end  = eof;
    bytes_to_send.push_back(b);
  endfunction

  function automatic logic [7:0] any_unprintable();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, int'(prx_pkg::PRINT_LO) - 1));
    end
    return 8'($urandom_range(int'(prx_pkg::PRINT_HI) + 1, 255));
  endfunction

  // one run of printable bytes closed by an unprintable byte, sometimes led by a noise byte
  function automatic int unsigned queue_run(int unsigned long_pct);
    int unsigned len;
    int unsigned added;
    added = 0;
    if ($urandom_range(0, 99) < 15) begin
      queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      added++;
    end
    len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(60, 70) : $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom_range(int'(prx_pkg::PRINT_LO), int'(prx_pkg::PRINT_HI))),
                 $urandom_range(0, 39) == 0);
    end
    queue_byte(any_unprintable(), $urandom_range(0, 5) == 0);
    return added + len + 1;
  endfunction

  function automatic void queue_runs(int unsigned count, int unsigned long_pct);
    int unsigned n;
    n = 0;
    while (n < count) begin
      n += queue_run(long_pct);
    end
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (bytes_to_send.size() != 0 || in_valid || pending_emits.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_min_len(logic [prx_pkg::MinLenW-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {prx_pkg::REG_MIN_LEN, 2'b00};
    pwdata  <= prx_pkg::PdataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_len = int'(v);
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[prx_pkg::MinLenW-1:0] !== v) begin
      flag_error($sformatf("min_length readback expected %0d got %0d", v,
                           prdata[prx_pkg::MinLenW-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  assign in_fire = in_valid && !in_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      send_gap <= 0;
    end else begin
      if (in_fire) begin
        predict_emission(in_beat);
      end
      if (!in_valid || in_fire) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idle_on && bytes_to_send.size() != 0 && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 12);
        end else if (bytes_to_send.size() != 0) begin
          in_beat  <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_beat(out_beat);
      end
      if (hold_req && !hold_done) begin
        hold_done  <= 1'b1;
        stall_left <= LongHold;
        out_stall  <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL printable_run_extractor");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // min_length at its reset value
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(prx_pkg::PRINT_LO, 1'b0);
    queue_byte(prx_pkg::PRINT_HI, 1'b0);
    queue_byte(8'h21, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h0A, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h79, 1'b0);
    queue_byte(8'h7A, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h74, 1'b0);
    queue_byte(8'h65, 1'b0);
    queue_byte(8'h73, 1'b0);
    queue_byte(8'h74, 1'b0);
    queue_byte(8'h0D, 1'b1);
    queue_byte(8'h00, 1'b1);
    wait_drained();

    // zero minimum: every unprintable byte reports
    set_min_len(7'd0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h09, 1'b0);
    queue_runs(20, 5);
    wait_drained();

    // large minimum: only overflowed runs report
    set_min_len(7'd64);
    void'(queue_run(100));
    queue_runs(10, 30);
    wait_drained();

    // long receiver hold while the sender keeps offering
    set_min_len(7'($urandom_range(1, 4)));
    hold_req <= 1'b1;
    queue_runs(25, 5);
    wait_drained();

    idle_on = 1'b0;
    set_min_len(7'd63);
    queue_runs(15, 0);
    wait_drained();

    if (mismatches == 0) begin
      $display("PASS printable_run_extractor");
    end else begin
      $display("FAIL printable_run_extractor");
    end
    $finish;
  end

endmodule
